// ----- rtl/emb3_pkg.sv -----
`timescale 1ns / 1ps

package emb3_pkg;

  localparam int unsigned CFG_W_W     = 12;
  localparam int unsigned CFG_H_W     = 13;
  localparam int unsigned CFG_DATA_W  = 13;
  localparam int unsigned CFG_IDX_W   = 1;
  localparam int unsigned CHAN_W      = 8;
  localparam int unsigned PIX_W       = 3 * CHAN_W;
  localparam int unsigned OUT_ROW_W   = 12;
  localparam int unsigned OUT_COL_W   = 11;
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QLVL_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'b1;

  localparam logic [CFG_W_W-1:0] FRAME_WIDTH_RST  = 12'd640;
  localparam logic [CFG_H_W-1:0] FRAME_HEIGHT_RST = 13'd480;

  typedef struct packed {
    logic [OUT_ROW_W-1:0] row;
    logic [OUT_COL_W-1:0] col;
    logic [PIX_W-1:0]     cur;
    logic [PIX_W-1:0]     old;
    logic                 last;
  } emb3_job_t;

  function automatic logic [CHAN_W-1:0] emboss_chan(input logic [CHAN_W-1:0] cur,
                                                    input logic [CHAN_W-1:0] old);
    logic signed [CHAN_W+1:0] v;
    logic [CHAN_W-1:0]        res;
    v = signed'({2'b00, cur}) - signed'({2'b00, old}) + 10'sd128;
    if (v < 10'sd0) begin
      res = '0;
    end else if (v > 10'sd255) begin
      res = '1;
    end else begin
      res = v[CHAN_W-1:0];
    end
    return res;
  endfunction

endpackage

// ----- rtl/emb3_queue.sv -----
`timescale 1ns / 1ps

module emb3_queue (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        push,
  input  emb3_pkg::emb3_job_t         push_job,
  input  logic                        pop,
  output emb3_pkg::emb3_job_t         head_job,
  output logic                        empty,
  output logic [emb3_pkg::QLVL_W-1:0] level
);
  import emb3_pkg::*;

  emb3_job_t         entries_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QLVL_W-1:0] level_r, level_nxt;

  assign head_job = entries_r[rd_ptr_r];
  assign empty    = (level_r == '0);
  assign level    = level_r;

  always_comb begin
    rd_ptr_nxt = pop  ? QPTR_W'(rd_ptr_r + 1'b1) : rd_ptr_r;
    wr_ptr_nxt = push ? QPTR_W'(wr_ptr_r + 1'b1) : wr_ptr_r;
    level_nxt  = level_r;
    if (push && !pop) begin
      level_nxt = QLVL_W'(level_r + 1'b1);
    end else if (pop && !push) begin
      level_nxt = QLVL_W'(level_r - 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_ptr_r <= '0;
      wr_ptr_r <= '0;
      level_r  <= '0;
    end else begin
      rd_ptr_r <= rd_ptr_nxt;
      wr_ptr_r <= wr_ptr_nxt;
      level_r  <= level_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries_r[wr_ptr_r] <= push_job;
    end
  end

endmodule

// ----- rtl/emb3_front.sv -----
`timescale 1ns / 1ps

module emb3_front #(
  parameter int unsigned MAX_WIDTH  = 2048,
  parameter int unsigned MAX_HEIGHT = 4096
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_wr_en,
  input  logic [emb3_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [emb3_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic                            in_first_of_frame,
  input  logic [emb3_pkg::CHAN_W-1:0]     in_blue,
  input  logic [emb3_pkg::CHAN_W-1:0]     in_green,
  input  logic [emb3_pkg::CHAN_W-1:0]     in_red,
  input  logic [emb3_pkg::QLVL_W-1:0]     q_level,
  output logic                            push,
  output emb3_pkg::emb3_job_t             push_job
);
  import emb3_pkg::*;

  localparam int unsigned DEPTH = 2 * MAX_WIDTH + 2;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned CW    = $clog2(MAX_WIDTH);
  localparam int unsigned RW    = $clog2(MAX_HEIGHT);

  function automatic logic [CW:0] clamp_w(input logic [CFG_W_W-1:0] raw);
    int unsigned v;
    v = 32'(raw);
    if (v < 3) begin
      v = 3;
    end else if (v > MAX_WIDTH) begin
      v = MAX_WIDTH;
    end
    return (CW + 1)'(v);
  endfunction

  function automatic logic [RW:0] clamp_h(input logic [CFG_H_W-1:0] raw);
    int unsigned v;
    v = 32'(raw);
    if (v < 3) begin
      v = 3;
    end else if (v > MAX_HEIGHT) begin
      v = MAX_HEIGHT;
    end
    return (RW + 1)'(v);
  endfunction

  // read offset in the ring: depth minus the two-rows-two-pixels distance
  function automatic logic [AW-1:0] ring_off(input logic [CW:0] w);
    return AW'(2 * (MAX_WIDTH - 32'(w)));
  endfunction

  logic [PIX_W-1:0] mem [DEPTH];
  logic [PIX_W-1:0] old_r;

  logic [CW:0]   w_r, w_nxt;
  logic [CW-1:0] w_m1_r, w_m1_nxt;
  logic [AW-1:0] off_r, off_nxt;
  logic [RW:0]   h_r, h_nxt;
  logic [RW-1:0] h_m1_r, h_m1_nxt;

  logic [CW-1:0] col_r, col_nxt;
  logic [RW-1:0] row_r, row_nxt;
  logic [AW-1:0] wp_r, wp_nxt;

  logic                 m_valid_r, m_valid_nxt;
  logic [OUT_ROW_W-1:0] m_row_r;
  logic [OUT_COL_W-1:0] m_col_r;
  logic [PIX_W-1:0]     m_cur_r;
  logic                 m_last_r;

  logic          accept;
  logic [CW-1:0] c_cur;
  logic [RW-1:0] r_cur;
  logic [CW:0]   c_inc;
  logic [RW:0]   r_inc;
  logic          emit;
  logic          last;
  logic [AW:0]   ra_sum;
  logic [AW-1:0] rd_addr;
  logic [CW:0]   cw_clamped;
  logic [RW:0]   ch_clamped;
  logic [PIX_W-1:0] cur_pix;

  assign in_stall = ((QLVL_W + 1)'(q_level) + (QLVL_W + 1)'(m_valid_r))
                    >= (QLVL_W + 1)'(QUEUE_DEPTH);
  assign accept   = in_valid && !in_stall;
  assign cur_pix  = {in_red, in_green, in_blue};

  // config
  always_comb begin
    cw_clamped = clamp_w(cfg_data[CFG_W_W-1:0]);
    ch_clamped = clamp_h(cfg_data[CFG_H_W-1:0]);
    w_nxt      = w_r;
    w_m1_nxt   = w_m1_r;
    off_nxt    = off_r;
    h_nxt      = h_r;
    h_m1_nxt   = h_m1_r;
    if (cfg_wr_en) begin
      case (cfg_index)
        REG_FRAME_WIDTH: begin
          w_nxt    = cw_clamped;
          w_m1_nxt = CW'(cw_clamped - 1'b1);
          off_nxt  = ring_off(cw_clamped);
        end
        REG_FRAME_HEIGHT: begin
          h_nxt    = ch_clamped;
          h_m1_nxt = RW'(ch_clamped - 1'b1);
        end
        default: begin
        end
      endcase
    end
  end

  // position and classification
  always_comb begin
    c_cur   = in_first_of_frame ? '0 : col_r;
    r_cur   = in_first_of_frame ? '0 : row_r;
    emit    = (c_cur >= CW'(2)) && (r_cur >= RW'(2))
              && ((CW + 1)'(c_cur) < w_r) && ((RW + 1)'(r_cur) < h_r);
    last    = (c_cur == w_m1_r) && (r_cur == h_m1_r);
    c_inc   = (CW + 1)'(c_cur) + 1'b1;
    r_inc   = (RW + 1)'(r_cur) + 1'b1;
    col_nxt = col_r;
    row_nxt = row_r;
    if (accept) begin
      if (c_inc >= w_r) begin
        col_nxt = '0;
        row_nxt = (r_inc >= h_r) ? '0 : RW'(r_inc);
      end else begin
        col_nxt = CW'(c_inc);
        row_nxt = r_cur;
      end
    end
    ra_sum  = (AW + 1)'(wp_r) + (AW + 1)'(off_r);
    rd_addr = (ra_sum >= (AW + 1)'(DEPTH)) ? AW'(ra_sum - (AW + 1)'(DEPTH)) : AW'(ra_sum);
    wp_nxt  = wp_r;
    if (accept) begin
      wp_nxt = (wp_r == AW'(DEPTH - 1)) ? '0 : AW'(wp_r + 1'b1);
    end
    m_valid_nxt = accept && emit;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w_r       <= clamp_w(FRAME_WIDTH_RST);
      w_m1_r    <= CW'(clamp_w(FRAME_WIDTH_RST) - 1'b1);
      off_r     <= ring_off(clamp_w(FRAME_WIDTH_RST));
      h_r       <= clamp_h(FRAME_HEIGHT_RST);
      h_m1_r    <= RW'(clamp_h(FRAME_HEIGHT_RST) - 1'b1);
      col_r     <= '0;
      row_r     <= '0;
      wp_r      <= '0;
      m_valid_r <= 1'b0;
    end else begin
      w_r       <= w_nxt;
      w_m1_r    <= w_m1_nxt;
      off_r     <= off_nxt;
      h_r       <= h_nxt;
      h_m1_r    <= h_m1_nxt;
      col_r     <= col_nxt;
      row_r     <= row_nxt;
      wp_r      <= wp_nxt;
      m_valid_r <= m_valid_nxt;
    end
  end

  // delay line, read before write on the same entry
  always_ff @(posedge clk) begin
    if (accept) begin
      old_r     <= mem[rd_addr];
      mem[wp_r] <= cur_pix;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      m_row_r  <= OUT_ROW_W'(r_cur - 1'b1);
      m_col_r  <= OUT_COL_W'(c_cur - 1'b1);
      m_cur_r  <= cur_pix;
      m_last_r <= last;
    end
  end

  assign push          = m_valid_r;
  assign push_job.row  = m_row_r;
  assign push_job.col  = m_col_r;
  assign push_job.cur  = m_cur_r;
  assign push_job.old  = old_r;
  assign push_job.last = m_last_r;

endmodule

// ----- rtl/emb3_back.sv -----
`timescale 1ns / 1ps

module emb3_back (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           q_empty,
  input  emb3_pkg::emb3_job_t            head_job,
  output logic                           pop,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [emb3_pkg::OUT_ROW_W-1:0] out_row,
  output logic [emb3_pkg::OUT_COL_W-1:0] out_col,
  output logic [emb3_pkg::CHAN_W-1:0]    out_blue,
  output logic [emb3_pkg::CHAN_W-1:0]    out_green,
  output logic [emb3_pkg::CHAN_W-1:0]    out_red,
  output logic                           out_last
);
  import emb3_pkg::*;

  logic                 valid_r, valid_nxt;
  logic [OUT_ROW_W-1:0] row_r;
  logic [OUT_COL_W-1:0] col_r;
  logic [CHAN_W-1:0]    blue_r, green_r, red_r;
  logic                 last_r;

  assign pop       = !q_empty && (!valid_r || !out_stall);
  assign valid_nxt = pop || (valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      row_r   <= head_job.row;
      col_r   <= head_job.col;
      blue_r  <= emboss_chan(head_job.cur[CHAN_W-1:0], head_job.old[CHAN_W-1:0]);
      green_r <= emboss_chan(head_job.cur[2*CHAN_W-1:CHAN_W],
                             head_job.old[2*CHAN_W-1:CHAN_W]);
      red_r   <= emboss_chan(head_job.cur[3*CHAN_W-1:2*CHAN_W],
                             head_job.old[3*CHAN_W-1:2*CHAN_W]);
      last_r  <= head_job.last;
    end
  end

  assign out_valid = valid_r;
  assign out_row   = row_r;
  assign out_col   = col_r;
  assign out_blue  = blue_r;
  assign out_green = green_r;
  assign out_red   = red_r;
  assign out_last  = last_r;

endmodule

// ----- rtl/color_emboss_3x3_unit.sv -----
`timescale 1ns / 1ps
// an accepted beat passes the front stage register, the queue and the output register
// throughput: one pixel per cycle unless in_stall; one delay line read and write a cycle
// border pixels take an input beat and give no result beat
// reset (synchronous, rst_n low) clears position counters, ring pointer, queue and valids;
// frame size returns to 640 x 480, delay line contents stay undefined until written

module color_emboss_3x3_unit #(
  parameter int unsigned MAX_WIDTH  = 2048,
  parameter int unsigned MAX_HEIGHT = 4096
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_wr_en,
  input  logic [emb3_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [emb3_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic                            in_first_of_frame,
  input  logic [emb3_pkg::CHAN_W-1:0]     in_blue,
  input  logic [emb3_pkg::CHAN_W-1:0]     in_green,
  input  logic [emb3_pkg::CHAN_W-1:0]     in_red,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [emb3_pkg::OUT_ROW_W-1:0]  out_row,
  output logic [emb3_pkg::OUT_COL_W-1:0]  out_col,
  output logic [emb3_pkg::CHAN_W-1:0]     out_blue,
  output logic [emb3_pkg::CHAN_W-1:0]     out_green,
  output logic [emb3_pkg::CHAN_W-1:0]     out_red,
  output logic                            out_last
);
  import emb3_pkg::*;

  logic              push;
  emb3_job_t         push_job;
  logic              pop;
  emb3_job_t         head_job;
  logic              q_empty;
  logic [QLVL_W-1:0] q_level;

  emb3_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_front (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_first_of_frame (in_first_of_frame),
    .in_blue           (in_blue),
    .in_green          (in_green),
    .in_red            (in_red),
    .q_level           (q_level),
    .push              (push),
    .push_job          (push_job)
  );

  emb3_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .head_job (head_job),
    .empty    (q_empty),
    .level    (q_level)
  );

  emb3_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .head_job  (head_job),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_row   (out_row),
    .out_col   (out_col),
    .out_blue  (out_blue),
    .out_green (out_green),
    .out_red   (out_red),
    .out_last  (out_last)
  );

endmodule
